// ----- design/fjpt_pkg.sv -----
// ----------------------------------------------------------------------------
// fjpt_pkg
// Shared types and constants for the flat JSON property tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package fjpt_pkg;

	localparam int OFS_W   = 13;
	localparam int IDX_W   = 6;
	localparam int CNT_OUT_W = 7;
	localparam int LIMIT_W = 7;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	localparam logic KIND_PROP = 1'b0;
	localparam logic KIND_END  = 1'b1;

	localparam logic [1:0] END_BRACE  = 2'd0;
	localparam logic [1:0] END_LIMIT  = 2'd1;
	localparam logic [1:0] END_PACKET = 2'd2;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;

	typedef enum logic [7:0] {
		PH_OBJ_START    = 8'b0000_0001,
		PH_KEY_OR_END   = 8'b0000_0010,
		PH_IN_KEY       = 8'b0000_0100,
		PH_COLON        = 8'b0000_1000,
		PH_VALUE        = 8'b0001_0000,
		PH_IN_QVALUE    = 8'b0010_0000,
		PH_IN_BARE      = 8'b0100_0000,
		PH_COMMA_OR_END = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_word_t;

	typedef struct packed {
		logic                 kind;
		logic [IDX_W-1:0]     prop_index;
		logic [OFS_W-1:0]     key_start;
		logic [OFS_W-1:0]     key_stop;
		logic [OFS_W-1:0]     value_start;
		logic [OFS_W-1:0]     value_stop;
		logic                 value_quoted;
		logic [CNT_OUT_W-1:0] prop_count;
		logic [1:0]           end_reason;
		logic                 last_result;
	} out_word_t;

	// one queue slot: all words caused by one input byte
	typedef struct packed {
		logic      two;
		out_word_t r0;
		out_word_t r1;
	} q_entry_t;

endpackage

`default_nettype wire

// ----- design/fjpt_front.sv -----
// ----------------------------------------------------------------------------
// fjpt_front
// Byte parser: tracks the object phase and builds the result words of a byte.
// ----------------------------------------------------------------------------
`default_nettype none

module fjpt_front import fjpt_pkg::*; #(
	parameter int MAX_LEN   = 4096,
	parameter int MAX_PROPS = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               take,
	input  wire in_word_t           word,
	input  wire logic               cfg_wr_en,
	input  wire logic [LIMIT_W-1:0] cfg_wr_data,
	output logic                    push,
	output q_entry_t                entry
);

	localparam int POS_W = $clog2(MAX_LEN + 1);
	localparam int CNT_W = $clog2(MAX_PROPS + 1);
	localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

	logic [LIMIT_W-1:0] limit_q;
	phase_t             phase_q;
	logic [POS_W-1:0]   pos_q;
	logic [CNT_W-1:0]   found_q;
	logic [POS_W-1:0]   hks_q;
	logic [POS_W-1:0]   hke_q;
	logic [POS_W-1:0]   hvs_q;
	logic               finished_q;

	phase_t             phase_d;
	logic [POS_W-1:0]   pos_next;
	logic [POS_W-1:0]   hks_d;
	logic [POS_W-1:0]   hke_d;
	logic [POS_W-1:0]   hvs_d;
	logic [CMP_W-1:0]   lim_x;
	logic [CMP_W-1:0]   lim_c;
	logic               ws;
	logic               prop_emit;
	logic [POS_W-1:0]   prop_stop;
	logic               prop_quoted;
	logic               end_emit;
	logic [1:0]         end_rsn;
	logic [CNT_W-1:0]   found_d;
	logic [7:0]         b;
	out_word_t          prop_w;
	out_word_t          end_w;

	assign b        = word.data_byte;
	assign pos_next = (pos_q == POS_W'(MAX_LEN)) ? pos_q : pos_q + 1'b1;
	assign lim_x    = CMP_W'(limit_q);
	assign lim_c    = (lim_x > CMP_W'(MAX_PROPS)) ? CMP_W'(MAX_PROPS) : lim_x;
	assign ws       = b inside {CH_SPACE, CH_TAB, CH_CR, CH_LF};

	always_comb begin
		phase_d     = phase_q;
		hks_d       = hks_q;
		hke_d       = hke_q;
		hvs_d       = hvs_q;
		prop_emit   = 1'b0;
		prop_stop   = pos_q;
		prop_quoted = 1'b0;
		end_emit    = 1'b0;
		end_rsn     = END_BRACE;

		case (phase_q)
			PH_OBJ_START: begin
				if (b == CH_LBRACE) phase_d = PH_KEY_OR_END;
			end
			PH_KEY_OR_END: begin
				if (b == CH_RBRACE) begin
					end_emit = 1'b1;
				end else if (b == CH_QUOTE) begin
					if (CMP_W'(found_q) < lim_c) begin
						hks_d   = pos_next;
						phase_d = PH_IN_KEY;
					end else begin
						end_emit = 1'b1;
						end_rsn  = END_LIMIT;
					end
				end
			end
			PH_IN_KEY: begin
				if (b == CH_QUOTE) begin
					hke_d   = pos_q;
					phase_d = PH_COLON;
				end
			end
			PH_COLON: begin
				if (b == CH_COLON) phase_d = PH_VALUE;
			end
			PH_VALUE: begin
				if (!ws) begin
					hvs_d = pos_q;
					if (b == CH_QUOTE) begin
						phase_d = PH_IN_QVALUE;
					end else if (b == CH_COMMA || b == CH_RBRACE) begin
						prop_emit = 1'b1;
						phase_d   = (b == CH_COMMA) ? PH_KEY_OR_END : PH_COMMA_OR_END;
						end_emit  = (b == CH_RBRACE);
					end else begin
						phase_d = PH_IN_BARE;
					end
				end
			end
			PH_IN_QVALUE: begin
				if (b == CH_QUOTE) begin
					prop_emit   = 1'b1;
					prop_quoted = 1'b1;
					phase_d     = PH_COMMA_OR_END;
				end
			end
			PH_IN_BARE: begin
				if (b == CH_COMMA || b == CH_RBRACE) begin
					prop_emit = 1'b1;
					phase_d   = (b == CH_COMMA) ? PH_KEY_OR_END : PH_COMMA_OR_END;
					end_emit  = (b == CH_RBRACE);
				end
			end
			PH_COMMA_OR_END: begin
				if (b == CH_COMMA) phase_d = PH_KEY_OR_END;
				else if (b == CH_RBRACE) end_emit = 1'b1;
			end
			default: phase_d = PH_OBJ_START;
		endcase

		// packet end closes an open value, then reports
		if (word.last_byte && !end_emit) begin
			if (phase_d == PH_IN_QVALUE || phase_d == PH_IN_BARE) begin
				prop_emit   = 1'b1;
				prop_stop   = pos_next;
				prop_quoted = (phase_d == PH_IN_QVALUE);
			end
			end_emit = 1'b1;
			end_rsn  = END_PACKET;
		end
	end

	assign found_d = found_q + CNT_W'(prop_emit);

	always_comb begin
		prop_w              = '0;
		prop_w.kind         = KIND_PROP;
		prop_w.prop_index   = IDX_W'(found_q);
		prop_w.key_start    = OFS_W'(hks_d);
		prop_w.key_stop     = OFS_W'(hke_d);
		prop_w.value_start  = OFS_W'(hvs_d);
		prop_w.value_stop   = OFS_W'(prop_stop);
		prop_w.value_quoted = prop_quoted;
		prop_w.last_result  = !end_emit;

		end_w             = '0;
		end_w.kind        = KIND_END;
		end_w.prop_count  = CNT_OUT_W'(found_d);
		end_w.end_reason  = end_rsn;
		end_w.last_result = 1'b1;

		entry.two = prop_emit && end_emit;
		entry.r0  = prop_emit ? prop_w : end_w;
		entry.r1  = end_w;
	end

	assign push = take && !finished_q && (prop_emit || end_emit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q    <= LIMIT_RESET;
			phase_q    <= PH_OBJ_START;
			pos_q      <= '0;
			found_q    <= '0;
			finished_q <= 1'b0;
			hks_q      <= '0;
			hke_q      <= '0;
			hvs_q      <= '0;
		end else begin
			if (cfg_wr_en) limit_q <= cfg_wr_data;
			if (take) begin
				if (word.last_byte) begin
					phase_q    <= PH_OBJ_START;
					pos_q      <= '0;
					found_q    <= '0;
					finished_q <= 1'b0;
				end else if (!finished_q) begin
					phase_q    <= phase_d;
					pos_q      <= pos_next;
					found_q    <= found_d;
					finished_q <= end_emit;
					hks_q      <= hks_d;
					hke_q      <= hke_d;
					hvs_q      <= hvs_d;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- design/fjpt_queue.sv -----
// ----------------------------------------------------------------------------
// fjpt_queue
// Short queue of per-byte result slots between the parser and the output.
// ----------------------------------------------------------------------------
`default_nettype none

module fjpt_queue import fjpt_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire q_entry_t wr_entry,
	input  wire logic     pop,
	output q_entry_t      head,
	output logic          empty,
	output logic          full
);

	q_entry_t          slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign head  = slot_q[rd_q];
	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= wr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop)  rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
		end
	end

endmodule

`default_nettype wire

// ----- design/fjpt_back.sv -----
// ----------------------------------------------------------------------------
// fjpt_back
// Output stage: splits queue slots into single words behind an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module fjpt_back import fjpt_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire q_entry_t head,
	input  wire logic     empty,
	output logic          pop,
	output logic          rec_valid,
	input  wire logic     rec_stall,
	output out_word_t     rec_word
);

	logic      out_valid_q;
	out_word_t out_q;
	logic      pend_valid_q;
	out_word_t pend_q;
	logic      load;

	assign load      = !out_valid_q || !rec_stall;
	assign pop       = load && !pend_valid_q && !empty;
	assign rec_valid = out_valid_q;
	assign rec_word  = out_q;

	// second word of a slot waits in pend_q and goes out before the next slot
	always_ff @(posedge clk) begin
		if (load) begin
			if (pend_valid_q) begin
				out_q <= pend_q;
			end else if (!empty) begin
				out_q  <= head.r0;
				pend_q <= head.r1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (load) begin
			if (pend_valid_q) begin
				out_valid_q  <= 1'b1;
				pend_valid_q <= 1'b0;
			end else begin
				out_valid_q  <= !empty;
				pend_valid_q <= !empty && head.two;
			end
		end
	end

endmodule

`default_nettype wire

// ----- design/flat_json_property_tokenizer_top.sv -----
// Throughput: one byte per cycle in, one word per cycle out with rec_stall low;
// a byte that closes a value together with the object gives two words, and the
// 4-slot queue between parser and output stage absorbs that until it fills and
// byte_stall rises. Words pass through a queue slot and the output register.
// Reset: parser returns to its start-of-packet state, property limit to 64,
// queue and output register empty.
// ----------------------------------------------------------------------------
// flat_json_property_tokenizer_top
// Streams packet bytes through a flat JSON object parser and emits records.
// ----------------------------------------------------------------------------
`default_nettype none

module flat_json_property_tokenizer_top import fjpt_pkg::*; #(
	parameter int MAX_LEN   = 4096,
	parameter int MAX_PROPS = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               byte_valid,
	output logic                    byte_stall,
	input  wire in_word_t           byte_word,
	output logic                    rec_valid,
	input  wire logic               rec_stall,
	output out_word_t               rec_word,
	input  wire logic               cfg_wr_en,
	input  wire logic [LIMIT_W-1:0] cfg_wr_data
);

	logic     take;
	logic     push;
	q_entry_t wr_entry;
	logic     pop;
	q_entry_t head;
	logic     empty;
	logic     full;

	assign byte_stall = full;
	assign take       = byte_valid && !full;

	fjpt_front #(
		.MAX_LEN   (MAX_LEN),
		.MAX_PROPS (MAX_PROPS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.word        (byte_word),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.push        (push),
		.entry       (wr_entry)
	);

	fjpt_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.head     (head),
		.empty    (empty),
		.full     (full)
	);

	fjpt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (empty),
		.pop       (pop),
		.rec_valid (rec_valid),
		.rec_stall (rec_stall),
		.rec_word  (rec_word)
	);

endmodule

`default_nettype wire

// ----- design/fjpt_checker.sv -----
// ----------------------------------------------------------------------------
// fjpt_checker
// Port-level checks on the record stream of the tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

module fjpt_checker import fjpt_pkg::*; (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               byte_valid,
	input wire logic               byte_stall,
	input wire in_word_t           byte_word,
	input wire logic               rec_valid,
	input wire logic               rec_stall,
	input wire out_word_t          rec_word,
	input wire logic               cfg_wr_en,
	input wire logic [LIMIT_W-1:0] cfg_wr_data
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && rec_stall |=> rec_valid && $stable(rec_word))
		else $error("stalled word changed");

	a_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && rec_word.kind == KIND_END |-> rec_word.last_result)
		else $error("end word not last of its byte");

	a_prop_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && rec_word.kind == KIND_PROP |->
			rec_word.prop_count == '0 && rec_word.end_reason == END_BRACE)
		else $error("property word carries end fields");

	a_reason: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && rec_word.kind == KIND_END |->
			rec_word.end_reason == END_BRACE || rec_word.end_reason == END_LIMIT ||
			rec_word.end_reason == END_PACKET)
		else $error("bad end reason");

	a_prop_follow: assert property (@(posedge clk) disable iff (!arst_n)
		rec_valid && !rec_stall && rec_word.kind == KIND_PROP && !rec_word.last_result
		|=> rec_valid && rec_word.kind == KIND_END)
		else $error("property without its end word");

endmodule

bind flat_json_property_tokenizer_top fjpt_checker u_fjpt_checker (.*);

`default_nettype wire

// ----- tb/tb_flat_json_property_tokenizer_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_flat_json_property_tokenizer_top
// Streams packet bytes into the flat JSON property tokenizer under random
// sender gaps and receiver stalls, tracks the object parse in a local model
// and checks every record word field by field, across several property limits.
// ----------------------------------------------------------------------------

module tb_flat_json_property_tokenizer_top;
	import fjpt_pkg::*;

	localparam int MAX_LEN        = 4096;
	localparam int MAX_PROPS      = 64;
	localparam int DRAIN_CYCLES   = 10;
	localparam int LONG_HOLD      = 400;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASE_BYTES    = 180;
	localparam int MAX_REPORTS    = 50;

	typedef enum int {PK_CLEAN, PK_CUT, PK_NOISY, PK_JUNK} packet_style_e;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 byte_valid = 1'b0;
	logic                 byte_stall;
	in_word_t             byte_word = '0;
	logic                 rec_valid;
	logic                 rec_stall = 1'b0;
	out_word_t            rec_word;
	logic                 cfg_wr_en = 1'b0;
	logic [LIMIT_W-1:0]   cfg_wr_data = '0;

	flat_json_property_tokenizer_top #(
		.MAX_LEN   (MAX_LEN),
		.MAX_PROPS (MAX_PROPS)
	) u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.byte_word   (byte_word),
		.rec_valid   (rec_valid),
		.rec_stall   (rec_stall),
		.rec_word    (rec_word),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// tokenizer model state
	phase_t             tk_phase;
	int                 tk_pos;
	int                 tk_found;
	int                 tk_key_start;
	int                 tk_key_stop;
	int                 tk_val_start;
	bit                 tk_done;
	logic [LIMIT_W-1:0] limit_reg;

	out_word_t  step_recs[$];
	out_word_t  expected_records[$];
	in_word_t   pending_bytes[$];
	logic [7:0] pk[$];

	int  bytes_queued;
	int  bytes_accepted;
	int  records_seen;
	int  error_count;
	int  limits_written;
	int  end_seen[3];
	int  send_gap;
	int  stall_left;
	int  hold_left;
	int  holds_wanted;
	int  holds_served;
	int  quiet_cycles;
	bit  sender_idle_on;
	bit  receiver_idle_on;

	function automatic void restart_packet();
		tk_phase     = PH_OBJ_START;
		tk_pos       = 0;
		tk_found     = 0;
		tk_key_start = 0;
		tk_key_stop  = 0;
		tk_val_start = 0;
		tk_done      = 1'b0;
	endfunction

	function automatic void emit_prop(input int stop, input bit quoted);
		out_word_t r;
		r              = '0;
		r.kind         = KIND_PROP;
		r.prop_index   = tk_found[IDX_W-1:0];
		r.key_start    = tk_key_start[OFS_W-1:0];
		r.key_stop     = tk_key_stop[OFS_W-1:0];
		r.value_start  = tk_val_start[OFS_W-1:0];
		r.value_stop   = stop[OFS_W-1:0];
		r.value_quoted = quoted;
		step_recs.push_back(r);
		tk_found++;
		tk_phase = PH_COMMA_OR_END;
	endfunction

	function automatic void emit_end(input logic [1:0] reason);
		out_word_t r;
		r            = '0;
		r.kind       = KIND_END;
		r.prop_count = tk_found[CNT_OUT_W-1:0];
		r.end_reason = reason;
		step_recs.push_back(r);
	endfunction

	// true when the byte closed the object
	function automatic bit comma_or_close(input logic [7:0] b);
		if (b == CH_COMMA) begin
			tk_phase = PH_KEY_OR_END;
		end else if (b == CH_RBRACE) begin
			emit_end(END_BRACE);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void tokenize_byte(input in_word_t w);
		logic [7:0] b;
		int         pos;
		int         nxt;
		int         lim;
		bit         ended;
		out_word_t  tail;
		b     = w.data_byte;
		pos   = tk_pos;
		nxt   = (pos + 1 > MAX_LEN) ? MAX_LEN : pos + 1;
		lim   = (int'(limit_reg) > MAX_PROPS) ? MAX_PROPS : int'(limit_reg);
		ended = 1'b0;
		step_recs.delete();
		if (tk_done) begin
			if (w.last_byte)
				restart_packet();
			return;
		end
		case (tk_phase)
			PH_OBJ_START: begin
				if (b == CH_LBRACE)
					tk_phase = PH_KEY_OR_END;
			end
			PH_KEY_OR_END: begin
				if (b == CH_RBRACE) begin
					emit_end(END_BRACE);
					ended = 1'b1;
				end else if (b == CH_QUOTE) begin
					if (tk_found < lim) begin
						tk_key_start = nxt;
						tk_phase     = PH_IN_KEY;
					end else begin
						emit_end(END_LIMIT);
						ended = 1'b1;
					end
				end
			end
			PH_IN_KEY: begin
				if (b == CH_QUOTE) begin
					tk_key_stop = pos;
					tk_phase    = PH_COLON;
				end
			end
			PH_COLON: begin
				if (b == CH_COLON)
					tk_phase = PH_VALUE;
			end
			PH_VALUE: begin
				if (!(b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF)) begin
					tk_val_start = pos;
					if (b == CH_QUOTE) begin
						tk_phase = PH_IN_QVALUE;
					end else if (b == CH_COMMA || b == CH_RBRACE) begin
						emit_prop(pos, 1'b0);
						ended = comma_or_close(b);
					end else begin
						tk_phase = PH_IN_BARE;
					end
				end
			end
			PH_IN_QVALUE: begin
				if (b == CH_QUOTE)
					emit_prop(pos, 1'b1);
			end
			PH_IN_BARE: begin
				if (b == CH_COMMA || b == CH_RBRACE) begin
					emit_prop(pos, 1'b0);
					ended = comma_or_close(b);
				end
			end
			PH_COMMA_OR_END: begin
				ended = comma_or_close(b);
			end
			default: begin
				tk_phase = PH_OBJ_START;
			end
		endcase

		// packet end closes an open value, then the end word
		if (w.last_byte && !ended) begin
			if (tk_phase == PH_IN_QVALUE)
				emit_prop(nxt, 1'b1);
			else if (tk_phase == PH_IN_BARE)
				emit_prop(nxt, 1'b0);
			emit_end(END_PACKET);
			ended = 1'b1;
		end

		if (step_recs.size() != 0) begin
			tail = step_recs.pop_back();
			tail.last_result = 1'b1;
			step_recs.push_back(tail);
		end
		foreach (step_recs[i])
			expected_records.push_back(step_recs[i]);

		if (w.last_byte) begin
			restart_packet();
		end else begin
			tk_pos = nxt;
			if (ended)
				tk_done = 1'b1;
		end
	endfunction

	function automatic void check_field(input string name, input logic [15:0] exp,
			input logic [15:0] got);
		if (got !== exp) begin
			if (error_count < MAX_REPORTS)
				$error("%s: expected %0d, got %0d", name, exp, got);
			error_count++;
		end
	endfunction

	function automatic void check_record(input out_word_t exp, input out_word_t got);
		check_field("kind", 16'(exp.kind), 16'(got.kind));
		check_field("prop_index", 16'(exp.prop_index), 16'(got.prop_index));
		check_field("key_start", 16'(exp.key_start), 16'(got.key_start));
		check_field("key_stop", 16'(exp.key_stop), 16'(got.key_stop));
		check_field("value_start", 16'(exp.value_start), 16'(got.value_start));
		check_field("value_stop", 16'(exp.value_stop), 16'(got.value_stop));
		check_field("value_quoted", 16'(exp.value_quoted), 16'(got.value_quoted));
		check_field("prop_count", 16'(exp.prop_count), 16'(got.prop_count));
		check_field("end_reason", 16'(exp.end_reason), 16'(got.end_reason));
		check_field("last_result", 16'(exp.last_result), 16'(got.last_result));
	endfunction

	// mostly zero, sometimes short, rarely a long gap
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] byte_not(input logic [7:0] a, input logic [7:0] c);
		logic [7:0] v;
		do
			v = 8'($urandom);
		while (v == a || v == c);
		return v;
	endfunction

	function automatic logic [7:0] syntax_byte();
		case ($urandom_range(0, 7))
			0: return CH_LBRACE;
			1: return CH_RBRACE;
			2: return CH_QUOTE;
			3: return CH_COLON;
			4: return CH_COMMA;
			5: return CH_SPACE;
			6: return CH_TAB;
			default: return CH_LF;
		endcase
	endfunction

	function automatic void add_blanks();
		if ($urandom_range(0, 9) < 3) begin
			repeat ($urandom_range(1, 3)) begin
				case ($urandom_range(0, 3))
					0: pk.push_back(CH_SPACE);
					1: pk.push_back(CH_TAB);
					2: pk.push_back(CH_CR);
					default: pk.push_back(CH_LF);
				endcase
			end
		end
	endfunction

	function automatic void append_text(input string s);
		for (int i = 0; i < s.len(); i++)
			pk.push_back(s[i]);
	endfunction

	// moves the assembled packet to the send queue, last flag on its final byte
	function automatic void flush_packet();
		in_word_t w;
		foreach (pk[i]) begin
			w.data_byte = pk[i];
			w.last_byte = (i == pk.size() - 1);
			pending_bytes.push_back(w);
			bytes_queued++;
		end
		pk.delete();
	endfunction

	function automatic void build_packet(input int n_props, input packet_style_e style);
		int cut;
		int idx;
		if (style == PK_JUNK) begin
			repeat ($urandom_range(1, 10))
				pk.push_back($urandom_range(0, 1) ? syntax_byte() : 8'($urandom));
			flush_packet();
			return;
		end
		if ($urandom_range(0, 9) == 0)
			pk.push_back(8'($urandom));
		pk.push_back(CH_LBRACE);
		add_blanks();
		for (int i = 0; i < n_props; i++) begin
			if (i != 0) begin
				pk.push_back(CH_COMMA);
				add_blanks();
			end
			pk.push_back(CH_QUOTE);
			repeat ($urandom_range(0, 4))
				pk.push_back(byte_not(CH_QUOTE, CH_QUOTE));
			pk.push_back(CH_QUOTE);
			add_blanks();
			pk.push_back(CH_COLON);
			add_blanks();
			case ($urandom_range(0, 5))
				0, 1: begin
					pk.push_back(CH_QUOTE);
					repeat ($urandom_range(0, 5))
						pk.push_back(byte_not(CH_QUOTE, CH_QUOTE));
					pk.push_back(CH_QUOTE);
				end
				5: begin
					// empty value
				end
				default: begin
					repeat ($urandom_range(1, 5))
						pk.push_back(byte_not(CH_COMMA, CH_RBRACE));
				end
			endcase
			add_blanks();
		end
		pk.push_back(CH_RBRACE);
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3))
				pk.push_back(8'($urandom));
		if (style == PK_CUT) begin
			cut = $urandom_range(1, pk.size());
			while (pk.size() > cut)
				void'(pk.pop_back());
		end else if (style == PK_NOISY) begin
			repeat ($urandom_range(1, 3)) begin
				idx = $urandom_range(0, pk.size() - 1);
				pk[idx] = $urandom_range(0, 1) ? syntax_byte() : 8'($urandom);
			end
		end
		flush_packet();
	endfunction

	task automatic write_limit(input logic [LIMIT_W-1:0] v);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		limit_reg = v;
		limits_written++;
	endtask

	task automatic wait_until_drained();
		while (bytes_accepted != bytes_queued || expected_records.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// byte sender
	always @(posedge clk) begin
		if (!arst_n) begin
			byte_valid <= 1'b0;
			send_gap   <= 0;
		end else begin
			if (byte_valid && !byte_stall) begin
				tokenize_byte(byte_word);
				bytes_accepted++;
			end
			if (!byte_valid || !byte_stall) begin
				if (send_gap > 0) begin
					byte_valid <= 1'b0;
					send_gap   <= send_gap - 1;
				end else if (pending_bytes.size() != 0) begin
					byte_word  <= pending_bytes.pop_front();
					byte_valid <= 1'b1;
					send_gap   <= sender_idle_on ? pick_gap() : 0;
				end else begin
					byte_valid <= 1'b0;
				end
			end
		end
	end

	// record receiver and checker
	always @(posedge clk) begin
		if (!arst_n) begin
			rec_stall  <= 1'b0;
			stall_left <= 0;
			hold_left  <= 0;
		end else begin
			if (rec_valid && !rec_stall) begin
				records_seen++;
				if (expected_records.size() == 0) begin
					if (error_count < MAX_REPORTS)
						$error("unexpected word: kind %0d index %0d", rec_word.kind,
							rec_word.prop_index);
					error_count++;
				end else begin
					check_record(expected_records.pop_front(), rec_word);
				end
				if (rec_word.kind == KIND_END && rec_word.end_reason <= END_PACKET)
					end_seen[rec_word.end_reason]++;
			end
			if (hold_left > 0) begin
				rec_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else if (holds_served != holds_wanted) begin
				// long hold-off so the output queue fills and backs up the input
				rec_stall    <= 1'b1;
				hold_left    <= LONG_HOLD - 1;
				holds_served <= holds_served + 1;
			end else if (stall_left > 0) begin
				rec_stall  <= 1'b1;
				stall_left <= stall_left - 1;
			end else begin
				rec_stall  <= 1'b0;
				stall_left <= receiver_idle_on ? pick_gap() : 0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((byte_valid && !byte_stall) || (rec_valid && !rec_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$error("no word moved for %0d cycles", quiet_cycles);
			$display("tb_flat_json_property_tokenizer_top failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		int            limit_plan[7];
		int            start;
		int            n_props;
		int            r;
		packet_style_e style;
		limit_plan = '{64, 1, 0, 127, 3, 64, 0};
		limit_plan[6] = $urandom_range(1, 64);
		restart_packet();
		limit_reg        = LIMIT_RESET;
		sender_idle_on   = 1'b1;
		receiver_idle_on = 1'b1;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty value closed with the object, then a byte after the end
		append_text("{\"a\":}}");
		flush_packet();
		// extreme bytes dropped, blanks between tokens, quoted value closed on last byte
		pk.push_back(8'hFF);
		pk.push_back(8'h00);
		append_text("{ \"k\"\t:\r\n\"v\"");
		flush_packet();
		// bare value still open at packet end
		append_text("{\"q\":7");
		flush_packet();
		// key still open at packet end
		append_text("{\"z");
		flush_packet();

		for (int p = 0; p < 7; p++) begin
			if (p != 0) begin
				wait_until_drained();
				write_limit(limit_plan[p][LIMIT_W-1:0]);
			end
			sender_idle_on   = (p % 3 != 2) && (p != 3);
			receiver_idle_on = (p % 2 == 0);
			start = bytes_queued;
			if (p == 3) begin
				// more keys than the limit allows; receiver holds off meanwhile
				build_packet(MAX_PROPS + 2, PK_CLEAN);
				holds_wanted++;
			end
			while (bytes_queued - start < PHASE_BYTES) begin
				r     = $urandom_range(0, 99);
				style = (r < 60) ? PK_CLEAN : (r < 75) ? PK_CUT : (r < 90) ? PK_NOISY : PK_JUNK;
				if (limit_reg <= 8 && $urandom_range(0, 3) == 0)
					n_props = int'(limit_reg) + $urandom_range(0, 2);
				else
					n_props = $urandom_range(0, 4);
				build_packet(n_props, style);
			end
		end

		wait_until_drained();
		$display("%0d bytes in %0d limit settings, %0d records checked",
			bytes_accepted, limits_written + 1, records_seen);
		$display("end records: brace %0d, limit %0d, packet end %0d",
			end_seen[0], end_seen[1], end_seen[2]);
		if (error_count == 0)
			$display("tb_flat_json_property_tokenizer_top passed");
		else
			$display("tb_flat_json_property_tokenizer_top failed");
		$finish;
	end

endmodule
